/* src/gbc_pkg.sv */
`timescale 1ns / 1ps
package gbc_pkg;

   // configuration register indexes
   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_ROWS  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_COLS  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_DIL   = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_LIMIT = 2'd3;
   localparam int CSR_DW = 15;

   // register reset values
   localparam logic [7:0]  ROWS_RESET  = 8'd128;
   localparam logic [7:0]  COLS_RESET  = 8'd128;
   localparam logic [3:0]  DIL_RESET   = 4'd6;
   localparam logic [14:0] LIMIT_RESET = 15'd300;

   // cell value that seeds a dilation square
   localparam logic [7:0] SEED_VALUE = 8'd20;

   // result field widths
   localparam int CENTER_W = 7;
   localparam int SIZE_W   = 15;

   // per-cell flags kept in the cell store
   typedef struct packed {
      logic seen;
      logic seed;
      logic occ;
   } cell_type;

   // one kept region as stored for emission
   typedef struct packed {
      logic [CENTER_W-1:0] row;
      logic [CENTER_W-1:0] col;
      logic [SIZE_W-1:0]   size;
   } region_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_DIL_SCAN,
      ST_DIL_CHECK,
      ST_SQ_RD,
      ST_SQ_WR,
      ST_LBL_RD,
      ST_LBL_CHECK,
      ST_Q_RD,
      ST_Q_WT,
      ST_NB_RD,
      ST_NB_WT,
      ST_REGION,
      ST_DIV,
      ST_EMIT_RD,
      ST_EMIT_WT
   } state_type;

endpackage

/* src/gbc_ram.sv */
`timescale 1ns / 1ps
module gbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/gbc_divider.sv */
`timescale 1ns / 1ps
module gbc_divider #(
   parameter int DW = 21,
   parameter int VW = 16,
   localparam int NW = $clog2(DW + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW:0]   rem_sh;
   logic [VW:0]   diff;
   logic          ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DW-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = NW'(DW);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/grid_blob_centroid_finder.sv */
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// req_      in         req_valid/stall    cell_value, last_cell
// rsp_      out        rsp_valid/stall    center_row/col, region_size, flags
// csr_      in         csr_write_enable   csr_index, csr_write_data
//
// Cells load one per cycle; the request with last_cell runs the frame: clear the
// unloaded cells, dilation scan (each interior seed marks its square, in-grid
// square cells are read and written back), labeling scan (each fresh occupied cell
// opens a region and its in-grid neighbors are searched breadth first), division
// per kept region, then one result per kept region and a closing result.
// Requests stall while the frame runs; synchronous reset clears control state only.
module grid_blob_centroid_finder #(
   parameter int MAX_ROWS    = 128,
   parameter int MAX_COLS    = 128,
   parameter int MAX_REGIONS = 63
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_cell_value,
   input  logic                        req_last_cell,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [gbc_pkg::CENTER_W-1:0] rsp_center_row,
   output logic [gbc_pkg::CENTER_W-1:0] rsp_center_col,
   output logic [gbc_pkg::SIZE_W-1:0]   rsp_region_size,
   output logic                        rsp_region_valid,
   output logic                        rsp_last_result,
   output logic                        rsp_regions_dropped,
   input  logic                        csr_write_enable,
   input  logic [gbc_pkg::CSR_IW-1:0]  csr_index,
   input  logic [gbc_pkg::CSR_DW-1:0]  csr_write_data
);
   import gbc_pkg::*;

   localparam int GRID = MAX_ROWS * MAX_COLS;
   localparam int AW   = $clog2(GRID);
   localparam int RW   = $clog2(MAX_ROWS);
   localparam int CW   = $clog2(MAX_COLS);
   localparam int RDW  = $clog2(MAX_ROWS + 1);
   localparam int CDW  = $clog2(MAX_COLS + 1);
   localparam int ERW  = RDW + 5;
   localparam int ECW  = CDW + 5;
   localparam int PW   = RDW + CDW;
   localparam int SZW  = (AW + 2 > SIZE_W) ? AW + 2 : SIZE_W;
   localparam int SRW  = RW + AW;
   localparam int SCW  = CW + AW;
   localparam int KW   = $clog2(MAX_REGIONS + 1);
   localparam int BAW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int QW   = RW + CW;

   // neighbor offset codes
   localparam logic [1:0] OFF_MINUS = 2'd0;
   localparam logic [1:0] OFF_ZERO  = 2'd1;
   localparam logic [1:0] OFF_PLUS  = 2'd2;

   state_type state_ff, state_in;

   logic [7:0]        rows_ff, cols_ff;
   logic [3:0]        dil_ff;
   logic [SIZE_W-1:0] limit_ff;

   logic [AW:0]     load_pos_ff, load_pos_in;
   logic [AW:0]     clr_ff, clr_in;
   logic [RDW-1:0]  scan_r_ff, scan_r_in;
   logic [CDW-1:0]  scan_c_ff, scan_c_in;
   logic [3:0]      sq_i_ff, sq_i_in, sq_j_ff, sq_j_in;
   logic [RW-1:0]   cur_r_ff, cur_r_in;
   logic [CW-1:0]   cur_c_ff, cur_c_in;
   logic [2:0]      nb_ff, nb_in;
   logic [AW:0]     head_ff, head_in, tail_ff, tail_in;
   logic [SRW-1:0]  sum_r_ff, sum_r_in;
   logic [SCW-1:0]  sum_c_ff, sum_c_in;
   logic [SZW-1:0]  count_ff, count_in;
   logic [KW-1:0]   kept_ff, kept_in, emit_ff, emit_in;
   logic            overflow_ff, overflow_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CENTER_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic                rsp_rv_ff, rsp_rv_in, rsp_last_ff, rsp_last_in;
   logic                rsp_drop_ff, rsp_drop_in;

   // effective geometry
   logic [31:0]    rows_wide, cols_wide, total_wide;
   logic [RDW-1:0] rows_eff;
   logic [CDW-1:0] cols_eff;
   logic [AW:0]    total;
   logic [2:0]     half;
   logic [ERW-1:0] h_r, rows_x, dil_r_end, rr;
   logic [ECW-1:0] h_c, cols_x, dil_c_end, cc;
   logic           dil_ok, sq_in_grid;

   // neighbor coordinates
   logic [1:0]     roff, coff;
   logic [RDW-1:0] nr;
   logic [CDW-1:0] nc;
   logic           nr_ok, nc_ok;

   // cell store address path
   logic [RDW-1:0] arow;
   logic [CDW-1:0] acol;
   logic [PW-1:0]  prod, addr_sum;
   logic [AW-1:0]  cell_addr;

   logic           cell_we;
   logic [AW-1:0]  cell_waddr;
   cell_type       cell_wdata, cell_rdata;
   logic           q_we;
   logic [AW-1:0]  q_waddr;
   logic [QW-1:0]  q_wdata, q_rdata;
   logic           b_we;
   region_type     b_wdata, b_rdata;

   logic           div_start, done_r, done_c;
   logic [SRW-1:0] quo_r;
   logic [SCW-1:0] quo_c;
   logic [SZW-1:0] size_full;
   logic           out_free;
   logic           adv_sq, adv_dil, adv_nb, adv_lbl, lbl_init;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= ROWS_RESET;
         cols_ff  <= COLS_RESET;
         dil_ff   <= DIL_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROWS:  rows_ff  <= csr_write_data[7:0];
            CSR_COLS:  cols_ff  <= csr_write_data[7:0];
            CSR_DIL:   dil_ff   <= csr_write_data[3:0];
            CSR_LIMIT: limit_ff <= csr_write_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped geometry and dilation window
   always_comb begin
      rows_wide = 32'(rows_ff);
      if (rows_wide == 32'd0) rows_wide = 32'd1;
      else if (rows_wide > 32'(MAX_ROWS)) rows_wide = 32'(MAX_ROWS);
      cols_wide = 32'(cols_ff);
      if (cols_wide == 32'd0) cols_wide = 32'd1;
      else if (cols_wide > 32'(MAX_COLS)) cols_wide = 32'(MAX_COLS);
      rows_eff   = rows_wide[RDW-1:0];
      cols_eff   = cols_wide[CDW-1:0];
      total_wide = rows_wide * cols_wide;
      total      = total_wide[AW:0];
      half       = dil_ff[3:1];
      h_r        = ERW'(half);
      h_c        = ECW'(half);
      rows_x     = ERW'(rows_eff);
      cols_x     = ECW'(cols_eff);
      dil_ok     = (rows_x > ERW'({half, 1'b0})) && (cols_x > ECW'({half, 1'b0}));
      dil_r_end  = rows_x - h_r;
      dil_c_end  = cols_x - h_c;
      rr         = ERW'(scan_r_ff) - h_r + ERW'(sq_i_ff);
      cc         = ECW'(scan_c_ff) - h_c + ECW'(sq_j_ff);
      sq_in_grid = (rr < rows_x) && (cc < cols_x);
   end

   // the eight neighbors of the current cell
   always_comb begin
      case (nb_ff)
         3'd0:    begin roff = OFF_MINUS; coff = OFF_MINUS; end
         3'd1:    begin roff = OFF_MINUS; coff = OFF_ZERO;  end
         3'd2:    begin roff = OFF_MINUS; coff = OFF_PLUS;  end
         3'd3:    begin roff = OFF_ZERO;  coff = OFF_MINUS; end
         3'd4:    begin roff = OFF_ZERO;  coff = OFF_PLUS;  end
         3'd5:    begin roff = OFF_PLUS;  coff = OFF_MINUS; end
         3'd6:    begin roff = OFF_PLUS;  coff = OFF_ZERO;  end
         default: begin roff = OFF_PLUS;  coff = OFF_PLUS;  end
      endcase
      case (roff)
         OFF_MINUS: begin
            nr    = RDW'(cur_r_ff) - 1'b1;
            nr_ok = cur_r_ff != '0;
         end
         OFF_PLUS: begin
            nr    = RDW'(cur_r_ff) + 1'b1;
            nr_ok = nr < rows_eff;
         end
         default: begin
            nr    = RDW'(cur_r_ff);
            nr_ok = 1'b1;
         end
      endcase
      case (coff)
         OFF_MINUS: begin
            nc    = CDW'(cur_c_ff) - 1'b1;
            nc_ok = cur_c_ff != '0;
         end
         OFF_PLUS: begin
            nc    = CDW'(cur_c_ff) + 1'b1;
            nc_ok = nc < cols_eff;
         end
         default: begin
            nc    = CDW'(cur_c_ff);
            nc_ok = 1'b1;
         end
      endcase
   end

   // row-major address of the cell the sequencer is looking at
   always_comb begin
      case (state_ff)
         ST_SQ_RD, ST_SQ_WR: begin
            arow = rr[RDW-1:0];
            acol = cc[CDW-1:0];
         end
         ST_NB_RD, ST_NB_WT: begin
            arow = nr;
            acol = nc;
         end
         default: begin
            arow = scan_r_ff;
            acol = scan_c_ff;
         end
      endcase
      prod      = PW'(arow) * PW'(cols_eff);
      addr_sum  = prod + PW'(acol);
      cell_addr = addr_sum[AW-1:0];
   end

   assign size_full = count_ff + 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // frame sequencer; flag updates during the scans are a read then a write back
   always_comb begin
      state_in    = state_ff;
      load_pos_in = load_pos_ff;
      clr_in      = clr_ff;
      scan_r_in   = scan_r_ff;
      scan_c_in   = scan_c_ff;
      sq_i_in     = sq_i_ff;
      sq_j_in     = sq_j_ff;
      cur_r_in    = cur_r_ff;
      cur_c_in    = cur_c_ff;
      nb_in       = nb_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      sum_r_in    = sum_r_ff;
      sum_c_in    = sum_c_ff;
      count_in    = count_ff;
      kept_in     = kept_ff;
      emit_in     = emit_ff;
      overflow_in = overflow_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_rv_in    = rsp_rv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      cell_we    = 1'b0;
      cell_waddr = cell_addr;
      cell_wdata = cell_rdata;
      q_we       = 1'b0;
      q_waddr    = tail_ff[AW-1:0];
      q_wdata    = {nr[RW-1:0], nc[CW-1:0]};
      b_we       = 1'b0;
      b_wdata    = '{row: CENTER_W'(quo_r), col: CENTER_W'(quo_c),
                     size: SIZE_W'(size_full)};
      div_start  = 1'b0;
      adv_sq     = 1'b0;
      adv_dil    = 1'b0;
      adv_nb     = 1'b0;
      adv_lbl    = 1'b0;
      lbl_init   = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (load_pos_ff < total) begin
                  cell_we     = 1'b1;
                  cell_waddr  = load_pos_ff[AW-1:0];
                  cell_wdata  = '{seen: 1'b0, seed: req_cell_value == SEED_VALUE,
                                  occ: req_cell_value != 8'd0};
                  load_pos_in = load_pos_ff + 1'b1;
               end
               if (req_last_cell) begin
                  clr_in   = load_pos_in;
                  state_in = ST_CLEAR;
               end
            end
         end
         // cells not loaded this frame are empty
         ST_CLEAR: begin
            if (clr_ff < total) begin
               cell_we    = 1'b1;
               cell_waddr = clr_ff[AW-1:0];
               cell_wdata = '0;
               clr_in     = clr_ff + 1'b1;
            end else if (dil_ok) begin
               scan_r_in = RDW'(half);
               scan_c_in = CDW'(half);
               state_in  = ST_DIL_SCAN;
            end else begin
               lbl_init = 1'b1;
            end
         end
         ST_DIL_SCAN: state_in = ST_DIL_CHECK;
         ST_DIL_CHECK: begin
            if (cell_rdata.seed) begin
               sq_i_in  = '0;
               sq_j_in  = '0;
               state_in = ST_SQ_RD;
            end else begin
               adv_dil = 1'b1;
            end
         end
         ST_SQ_RD: begin
            if (sq_in_grid) state_in = ST_SQ_WR;
            else adv_sq = 1'b1;
         end
         ST_SQ_WR: begin
            cell_we        = 1'b1;
            cell_wdata.occ = 1'b1;
            adv_sq         = 1'b1;
         end
         ST_LBL_RD: state_in = ST_LBL_CHECK;
         // a fresh occupied cell opens a region
         ST_LBL_CHECK: begin
            if (cell_rdata.occ && !cell_rdata.seen) begin
               cell_we         = 1'b1;
               cell_wdata.seen = 1'b1;
               q_we            = 1'b1;
               q_waddr         = '0;
               q_wdata         = {scan_r_ff[RW-1:0], scan_c_ff[CW-1:0]};
               head_in         = '0;
               tail_in         = (AW+1)'(1);
               sum_r_in        = '0;
               sum_c_in        = '0;
               count_in        = '0;
               state_in        = ST_Q_RD;
            end else begin
               adv_lbl = 1'b1;
            end
         end
         ST_Q_RD: state_in = ST_Q_WT;
         ST_Q_WT: begin
            cur_r_in = q_rdata[QW-1:CW];
            cur_c_in = q_rdata[CW-1:0];
            count_in = count_ff + 1'b1;
            sum_r_in = sum_r_ff + SRW'(q_rdata[QW-1:CW]);
            sum_c_in = sum_c_ff + SCW'(q_rdata[CW-1:0]);
            head_in  = head_ff + 1'b1;
            nb_in    = '0;
            state_in = ST_NB_RD;
         end
         ST_NB_RD: begin
            if (nr_ok && nc_ok) state_in = ST_NB_WT;
            else adv_nb = 1'b1;
         end
         // each cell is queued once, so the queue never overflows
         ST_NB_WT: begin
            if (cell_rdata.occ && !cell_rdata.seen) begin
               cell_we         = 1'b1;
               cell_wdata.seen = 1'b1;
               q_we            = 1'b1;
               tail_in         = tail_ff + 1'b1;
            end
            adv_nb = 1'b1;
         end
         ST_REGION: begin
            if (size_full < SZW'(limit_ff)) begin
               if (kept_ff < KW'(MAX_REGIONS)) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  overflow_in = 1'b1;
                  adv_lbl     = 1'b1;
               end
            end else begin
               adv_lbl = 1'b1;
            end
         end
         ST_DIV: begin
            if (done_r && done_c) begin
               b_we    = 1'b1;
               kept_in = kept_ff + 1'b1;
               adv_lbl = 1'b1;
            end
         end
         ST_EMIT_RD: begin
            if (out_free) begin
               if (emit_ff < kept_ff) begin
                  state_in = ST_EMIT_WT;
               end else begin
                  // closing result, then the frame state returns to empty
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = '0;
                  rsp_col_in   = '0;
                  rsp_size_in  = '0;
                  rsp_rv_in    = 1'b0;
                  rsp_last_in  = 1'b1;
                  rsp_drop_in  = overflow_ff;
                  load_pos_in  = '0;
                  kept_in      = '0;
                  emit_in      = '0;
                  overflow_in  = 1'b0;
                  state_in     = ST_LOAD;
               end
            end
         end
         ST_EMIT_WT: begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = b_rdata.row;
            rsp_col_in   = b_rdata.col;
            rsp_size_in  = b_rdata.size;
            rsp_rv_in    = 1'b1;
            rsp_last_in  = 1'b0;
            rsp_drop_in  = 1'b0;
            emit_in      = emit_ff + 1'b1;
            state_in     = ST_EMIT_RD;
         end
         default: state_in = ST_LOAD;
      endcase

      // next cell of the dilation square
      if (adv_sq) begin
         if (sq_j_ff != dil_ff) begin
            sq_j_in  = sq_j_ff + 1'b1;
            state_in = ST_SQ_RD;
         end else if (sq_i_ff != dil_ff) begin
            sq_i_in  = sq_i_ff + 1'b1;
            sq_j_in  = '0;
            state_in = ST_SQ_RD;
         end else begin
            adv_dil = 1'b1;
         end
      end

      // next seed candidate
      if (adv_dil) begin
         if (ECW'(scan_c_ff) + 1'b1 < dil_c_end) begin
            scan_c_in = scan_c_ff + 1'b1;
            state_in  = ST_DIL_SCAN;
         end else if (ERW'(scan_r_ff) + 1'b1 < dil_r_end) begin
            scan_r_in = scan_r_ff + 1'b1;
            scan_c_in = CDW'(half);
            state_in  = ST_DIL_SCAN;
         end else begin
            lbl_init = 1'b1;
         end
      end

      if (lbl_init) begin
         scan_r_in = '0;
         scan_c_in = '0;
         state_in  = ST_LBL_RD;
      end

      // next neighbor, next queued cell, or region done
      if (adv_nb) begin
         if (nb_ff != 3'd7) begin
            nb_in    = nb_ff + 1'b1;
            state_in = ST_NB_RD;
         end else if (head_ff < tail_in) begin
            state_in = ST_Q_RD;
         end else begin
            state_in = ST_REGION;
         end
      end

      // next cell of the labeling scan
      if (adv_lbl) begin
         if ((CDW+1)'(scan_c_ff) + 1'b1 < (CDW+1)'(cols_eff)) begin
            scan_c_in = scan_c_ff + 1'b1;
            state_in  = ST_LBL_RD;
         end else if ((RDW+1)'(scan_r_ff) + 1'b1 < (RDW+1)'(rows_eff)) begin
            scan_r_in = scan_r_ff + 1'b1;
            scan_c_in = '0;
            state_in  = ST_LBL_RD;
         end else begin
            emit_in  = '0;
            state_in = ST_EMIT_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_pos_ff  <= '0;
         kept_ff      <= '0;
         emit_ff      <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         kept_ff      <= kept_in;
         emit_ff      <= emit_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      clr_ff      <= clr_in;
      scan_r_ff   <= scan_r_in;
      scan_c_ff   <= scan_c_in;
      sq_i_ff     <= sq_i_in;
      sq_j_ff     <= sq_j_in;
      cur_r_ff    <= cur_r_in;
      cur_c_ff    <= cur_c_in;
      nb_ff       <= nb_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      sum_r_ff    <= sum_r_in;
      sum_c_ff    <= sum_c_in;
      count_ff    <= count_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_size_ff <= rsp_size_in;
      rsp_rv_ff   <= rsp_rv_in;
      rsp_last_ff <= rsp_last_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   // cell store: occupied, seed and seen flags per cell
   gbc_ram #(.WIDTH($bits(cell_type)), .DEPTH(GRID)) u_cells (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (cell_addr),
      .rd_data (cell_rdata)
   );

   // breadth-first search queue of cell coordinates
   gbc_ram #(.WIDTH(QW), .DEPTH(GRID)) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (head_ff[AW-1:0]),
      .rd_data (q_rdata)
   );

   // kept regions waiting for emission
   gbc_ram #(.WIDTH($bits(region_type)), .DEPTH(MAX_REGIONS)) u_regions (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (kept_ff[BAW-1:0]),
      .wr_data (b_wdata),
      .rd_addr (emit_ff[BAW-1:0]),
      .rd_data (b_rdata)
   );

   // centroid dividers
   gbc_divider #(.DW(SRW), .VW(SZW)) u_div_row (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_r_ff),
      .divisor  (count_ff),
      .done     (done_r),
      .quotient (quo_r)
   );

   gbc_divider #(.DW(SCW), .VW(SZW)) u_div_col (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_c_ff),
      .divisor  (count_ff),
      .done     (done_c),
      .quotient (quo_c)
   );

   assign req_stall           = state_ff != ST_LOAD;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_center_row      = rsp_row_ff;
   assign rsp_center_col      = rsp_col_ff;
   assign rsp_region_size     = rsp_size_ff;
   assign rsp_region_valid    = rsp_rv_ff;
   assign rsp_last_result     = rsp_last_ff;
   assign rsp_regions_dropped = rsp_drop_ff;

   // checks
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= KW'(MAX_REGIONS))
      else $error("kept region count past buffer depth");

   a_queue_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_Q_RD |-> head_ff < tail_ff)
      else $error("search queue popped while empty");

   a_closing_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> !rsp_rv_ff && rsp_size_ff == '0)
      else $error("closing result carries region fields");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD && req_valid && req_last_cell |=> state_ff == ST_CLEAR)
      else $error("last cell did not start frame processing");

endmodule

/* tb/grid_blob_centroid_finder_tb.sv */
`timescale 1ns / 1ps
module grid_blob_centroid_finder_tb;
   import gbc_pkg::*;

   localparam int GRID_MAX   = 128;
   localparam int REGION_CAP = 63;

   // one expected result as the block should emit it
   typedef struct {
      logic [CENTER_W-1:0] row;
      logic [CENTER_W-1:0] col;
      logic [SIZE_W-1:0]   size;
      logic                valid;
      logic                last;
      logic                dropped;
   } centroid_type;

   // predicts the centroid list of each frame and checks results against it
   class blob_scoreboard;
      bit occ[GRID_MAX*GRID_MAX];
      bit seed[GRID_MAX*GRID_MAX];
      bit seen[GRID_MAX*GRID_MAX];
      int bfs_q[GRID_MAX*GRID_MAX];
      int fill_pos;
      logic [7:0]  rows_reg;
      logic [7:0]  cols_reg;
      logic [3:0]  dil_reg;
      logic [14:0] limit_reg;
      centroid_type pending[$];
      int errors;

      function new();
         fill_pos  = 0;
         rows_reg  = ROWS_RESET;
         cols_reg  = COLS_RESET;
         dil_reg   = DIL_RESET;
         limit_reg = LIMIT_RESET;
         errors    = 0;
      endfunction

      function void set_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] data);
         case (idx)
            CSR_ROWS:  rows_reg  = data[7:0];
            CSR_COLS:  cols_reg  = data[7:0];
            CSR_DIL:   dil_reg   = data[3:0];
            CSR_LIMIT: limit_reg = data[14:0];
            default: ;
         endcase
      endfunction

      function int clamp_dim(int v);
         if (v < 1) return 1;
         if (v > GRID_MAX) return GRID_MAX;
         return v;
      endfunction

      // flood one region from start, collect sums and count
      function void flood(int start, int rows, int cols, output int cnt,
                          output longint sr, output longint sc);
         int qh, qt;
         int k, r, c, nr, nc, n;
         cnt = 0;
         sr = 0;
         sc = 0;
         qh = 0;
         qt = 0;
         seen[start] = 1;
         bfs_q[qt] = start;
         qt++;
         while (qh < qt) begin
            k = bfs_q[qh];
            qh++;
            r = k / cols;
            c = k % cols;
            cnt++;
            sr += r;
            sc += c;
            for (int dr = -1; dr <= 1; dr++)
               for (int dc = -1; dc <= 1; dc++) begin
                  nr = r + dr;
                  nc = c + dc;
                  if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
                     n = nr * cols + nc;
                     if (occ[n] && !seen[n]) begin
                        seen[n] = 1;
                        bfs_q[qt] = n;
                        qt++;
                     end
                  end
               end
         end
      endfunction

      function void note_request(logic [7:0] value, logic last);
         int rows, cols, total, d, half, rr, cc, cnt, size, kept;
         longint sr, sc;
         bit ovf;
         centroid_type e;
         rows  = clamp_dim(rows_reg);
         cols  = clamp_dim(cols_reg);
         total = rows * cols;
         if (fill_pos < total) begin
            occ[fill_pos]  = (value != 0);
            seed[fill_pos] = (value == SEED_VALUE);
            fill_pos++;
         end
         if (!last) return;
         for (int k = fill_pos; k < total; k++) begin
            occ[k]  = 0;
            seed[k] = 0;
         end
         for (int k = 0; k < total; k++) seen[k] = 0;
         // dilation squares around interior seeds
         d    = dil_reg;
         half = d / 2;
         if (rows > 2 * half && cols > 2 * half)
            for (int r = half; r < rows - half; r++)
               for (int c = half; c < cols - half; c++)
                  if (seed[r * cols + c])
                     for (int i = 0; i <= d; i++)
                        for (int j = 0; j <= d; j++) begin
                           rr = r - half + i;
                           cc = c - half + j;
                           if (rr < rows && cc < cols) occ[rr * cols + cc] = 1;
                        end
         // label regions in raster order of first cell
         kept = 0;
         ovf  = 0;
         for (int k = 0; k < total; k++) begin
            if (occ[k] && !seen[k]) begin
               flood(k, rows, cols, cnt, sr, sc);
               size = cnt + 1;
               if (size < limit_reg) begin
                  if (kept < REGION_CAP) begin
                     e.row     = CENTER_W'(sr / cnt);
                     e.col     = CENTER_W'(sc / cnt);
                     e.size    = SIZE_W'(size);
                     e.valid   = 1;
                     e.last    = 0;
                     e.dropped = 0;
                     pending = {pending, e};
                     kept++;
                  end else
                     ovf = 1;
               end
            end
         end
         e.row     = 0;
         e.col     = 0;
         e.size    = 0;
         e.valid   = 0;
         e.last    = 1;
         e.dropped = ovf;
         pending = {pending, e};
         fill_pos = 0;
      endfunction

      function void check_result(centroid_type got);
         centroid_type e;
         if (pending.size() == 0) begin
            $error("unexpected result row=%0d col=%0d size=%0d", got.row, got.col, got.size);
            errors++;
            return;
         end
         e = pending[0];
         pending.delete(0);
         if (got.row !== e.row) begin
            $error("center_row expected %0d actual %0d", e.row, got.row);
            errors++;
         end
         if (got.col !== e.col) begin
            $error("center_col expected %0d actual %0d", e.col, got.col);
            errors++;
         end
         if (got.size !== e.size) begin
            $error("region_size expected %0d actual %0d", e.size, got.size);
            errors++;
         end
         if (got.valid !== e.valid) begin
            $error("region_valid expected %0d actual %0d", e.valid, got.valid);
            errors++;
         end
         if (got.last !== e.last) begin
            $error("last_result expected %0d actual %0d", e.last, got.last);
            errors++;
         end
         if (got.dropped !== e.dropped) begin
            $error("regions_dropped expected %0d actual %0d", e.dropped, got.dropped);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [7:0] req_cell_value = 0;
   logic req_last_cell = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [CENTER_W-1:0] rsp_center_row;
   logic [CENTER_W-1:0] rsp_center_col;
   logic [SIZE_W-1:0]   rsp_region_size;
   logic rsp_region_valid;
   logic rsp_last_result;
   logic rsp_regions_dropped;
   logic csr_write_enable = 0;
   logic [CSR_IW-1:0] csr_index = CSR_ROWS;
   logic [CSR_DW-1:0] csr_write_data = 0;

   bit no_idle = 0;
   int sent = 0;
   blob_scoreboard sb = new();

   grid_blob_centroid_finder uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cell_value(req_cell_value), .req_last_cell(req_last_cell),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_center_row(rsp_center_row), .rsp_center_col(rsp_center_col),
      .rsp_region_size(rsp_region_size), .rsp_region_valid(rsp_region_valid),
      .rsp_last_result(rsp_last_result), .rsp_regions_dropped(rsp_regions_dropped),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // random result back-pressure
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 12);
   end

   // result monitor
   always @(posedge clock) begin
      centroid_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.row     = rsp_center_row;
         got.col     = rsp_center_col;
         got.size    = rsp_region_size;
         got.valid   = rsp_region_valid;
         got.last    = rsp_last_result;
         got.dropped = rsp_regions_dropped;
         sb.check_result(got);
      end
   end

   // one cell request, with random idle cycles ahead of it
   task send_cell(logic [7:0] value, logic last);
      while (!no_idle && $urandom_range(99) < 12) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid      <= 1;
      req_cell_value <= value;
      req_last_cell  <= last;
      do @(posedge clock); while (req_stall);
      sb.note_request(value, last);
      sent++;
   endtask

   // wait for the frame to drain before touching registers
   task settle();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task write_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] data);
      csr_write_enable <= 1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.set_reg(idx, data);
      @(posedge clock);
   endtask

   task set_geometry(int rows, int cols, int dil, int limit);
      settle();
      write_reg(CSR_ROWS, CSR_DW'(rows));
      write_reg(CSR_COLS, CSR_DW'(cols));
      write_reg(CSR_DIL, CSR_DW'(dil));
      write_reg(CSR_LIMIT, CSR_DW'(limit));
   endtask

   function logic [7:0] pick_cell();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 8'd0;
      if (r < 65) return SEED_VALUE;
      if (r < 72) return 8'd255;
      return 8'($urandom_range(1, 255));
   endfunction

   initial begin
      int rows, cols, total, n, r;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // short frame on the full-size reset grid, seed at the edge
      send_cell(SEED_VALUE, 0);
      send_cell(8'd0, 0);
      send_cell(8'd7, 0);
      send_cell(8'd255, 1);

      // fully occupied 3x3, no dilation, widest limit
      set_geometry(3, 3, 0, 15'h7FFF);
      for (int i = 0; i < 9; i++) send_cell(8'd255, i == 8);

      // zero rows clamp up, oversize cols clamp down, limit keeps nothing
      set_geometry(0, 255, 15, 1);
      send_cell(SEED_VALUE, 0);
      send_cell(8'd1, 0);
      send_cell(8'd128, 1);

      // single column grid with a small dilation
      set_geometry(255, 0, 2, 3);
      send_cell(8'd0, 0);
      send_cell(SEED_VALUE, 0);
      send_cell(8'd0, 0);
      send_cell(8'd5, 0);
      send_cell(8'd5, 1);

      // extra cells past the grid are ignored
      set_geometry(2, 1, 1, 100);
      send_cell(8'd64, 0);
      send_cell(8'd0, 0);
      send_cell(8'd32, 0);
      send_cell(8'd16, 1);

      // more isolated regions than the buffer holds
      set_geometry(1, 128, 0, 3);
      for (int i = 0; i < 128; i++)
         send_cell((i % 2) ? 8'd0 : 8'($urandom_range(1, 255)), i == 127);

      // random frames on small grids
      while (sent < 345) begin
         if ($urandom_range(99) < 40)
            set_geometry($urandom_range(1, 8), $urandom_range(1, 8),
                         ($urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(0, 15)),
                         ($urandom_range(2) == 0) ? 15'h7FFF : $urandom_range(1, 20));
         rows  = sb.clamp_dim(sb.rows_reg);
         cols  = sb.clamp_dim(sb.cols_reg);
         total = rows * cols;
         r = $urandom_range(99);
         if (r < 15) n = $urandom_range(1, total);
         else if (r < 25) n = total + $urandom_range(1, 3);
         else n = total;
         no_idle = (sent > 250 && sent < 310);
         for (int i = 0; i < n; i++) send_cell(pick_cell(), i == n - 1);
      end
      no_idle = 0;

      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule
